// ----- rtl/etf_pkg.sv -----
// Shared types and constants for the escape-time fractal unit.
// Holds the configuration register map, reset values and fixed-point limits.
// No dependencies; every other file of the block but etf_mul refers to it by scoped names.
package etf_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int STEP_W     = 31;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAILOUT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RE   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IM   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_C   = 4'd7;

    localparam int MAX_ITER_RST   = 32;
    localparam int MAX_ITER_MIN_W = 6;

    localparam logic [63:0]        PROD_LIM  = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] CROSS_LIM = 64'sh2000_0000_0000_0000;

    typedef struct packed {
        logic              mode;
        logic [2:0]        bailout;
        logic [31:0]       origin_re;
        logic [31:0]       origin_im;
        logic [STEP_W-1:0] step_re;
        logic [STEP_W-1:0] step_im;
        logic [63:0]       julia_c;
    } cfg_t;

    localparam cfg_t CFG_RST = '{
        mode:      1'b0,
        bailout:   3'd3,
        origin_re: 32'hD800_0000,
        origin_im: 32'hE800_0000,
        step_re:   31'd3355443,
        step_im:   31'd4026532,
        julia_c:   64'd0
    };

endpackage

// ----- rtl/etf_if.sv -----
// Handshake channels of the escape-time fractal unit: pixel in, result out, config writes.
// Each carries valid, ready and its payload; a beat moves when both are high.
// Depends on etf_pkg for the configuration index and data widths.
interface etf_pix_if #(parameter int COORD_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface etf_res_if #(parameter int ITER_BITS = 12);
    logic                 valid;
    logic                 ready;
    logic [ITER_BITS-1:0] escape_iter;
    logic                 inside_res;

    modport source (output valid, output escape_iter, output inside_res, input ready);
    modport sink   (input valid, input escape_iter, input inside_res, output ready);
endinterface

interface etf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [etf_pkg::CFG_IDX_W-1:0]    index;
    logic [etf_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/etf_cfg_regs.sv -----
// Configuration register file of the escape-time fractal unit.
// Decodes write beats by register index and holds the values for the datapath.
// Depends on etf_pkg and on etf_cfg_if from etf_if.sv.
module etf_cfg_regs #(
    parameter int ITER_BITS = 12,
    parameter int MI_W      = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    etf_cfg_if.sink             cfg,
    output etf_pkg::cfg_t       cfg_q,
    output logic [MI_W-1:0]     max_iter
);

    etf_pkg::cfg_t   cfg_reg;
    etf_pkg::cfg_t   cfg_next;
    logic [MI_W-1:0] max_iter_reg;
    logic [MI_W-1:0] max_iter_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;
    assign max_iter  = max_iter_reg;

    always_comb
    begin
        cfg_next      = cfg_reg;
        max_iter_next = max_iter_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                etf_pkg::REG_MODE:      cfg_next.mode      = cfg.data[0];
                etf_pkg::REG_MAX_ITER:  max_iter_next      = MI_W'(cfg.data[ITER_BITS-1:0]);
                etf_pkg::REG_BAILOUT:   cfg_next.bailout   = cfg.data[2:0];
                etf_pkg::REG_ORIGIN_RE: cfg_next.origin_re = cfg.data[31:0];
                etf_pkg::REG_ORIGIN_IM: cfg_next.origin_im = cfg.data[31:0];
                etf_pkg::REG_STEP_RE:   cfg_next.step_re   = cfg.data[etf_pkg::STEP_W-1:0];
                etf_pkg::REG_STEP_IM:   cfg_next.step_im   = cfg.data[etf_pkg::STEP_W-1:0];
                etf_pkg::REG_JULIA_C:   cfg_next.julia_c   = cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= etf_pkg::CFG_RST;
            max_iter_reg <= MI_W'(etf_pkg::MAX_ITER_RST);
        end
        else
        begin
            cfg_reg      <= cfg_next;
            max_iter_reg <= max_iter_next;
        end
    end

endmodule

// ----- rtl/etf_mul.sv -----
// Shared unsigned multiplier of the escape-time fractal unit.
// Forms an OPW x OPW product from four half-width partial products, one per cycle.
// No package dependencies; the product is valid in the cycle that done is high.
module etf_mul #(
    parameter int OPW = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [OPW-1:0]   a,
    input  logic [OPW-1:0]   b,
    output logic             done,
    output logic [2*OPW-1:0] prod
);

    localparam int H   = (OPW + 1) / 2;
    localparam int PPW = 2 * H;
    localparam int PW  = 2 * OPW;
    localparam logic [2:0] LAST_STEP = 3'd4;

    logic [OPW-1:0] a_reg;
    logic [OPW-1:0] a_next;
    logic [OPW-1:0] b_reg;
    logic [OPW-1:0] b_next;
    logic [2:0]     cnt_reg;
    logic [2:0]     cnt_next;
    logic           busy_reg;
    logic           busy_next;
    logic           done_reg;
    logic           done_next;
    logic [PPW-1:0] pp_reg;
    logic [PPW-1:0] pp_next;
    logic [1:0]     sh_reg;
    logic [1:0]     sh_next;
    logic [PW-1:0]  acc_reg;
    logic [PW-1:0]  acc_next;

    logic [H-1:0]   da;
    logic [H-1:0]   db;
    logic [PW-1:0]  pp_ext;
    logic [PW-1:0]  pp_shifted;

    assign da     = cnt_reg[1] ? H'(a_reg[OPW-1:H]) : a_reg[H-1:0];
    assign db     = cnt_reg[0] ? H'(b_reg[OPW-1:H]) : b_reg[H-1:0];
    assign pp_ext = PW'(pp_reg);

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_shifted = pp_ext;
            2'd1:    pp_shifted = pp_ext << H;
            default: pp_shifted = pp_ext << (2 * H);
        endcase
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        pp_next   = pp_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            cnt_next  = '0;
            busy_next = 1'b1;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (!cnt_reg[2])
            begin
                pp_next = da * db;
                sh_next = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (cnt_reg != 3'd0)
            begin
                acc_next = acc_reg + pp_shifted;
            end
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- rtl/escape_time_fractal_unit_core.sv -----
// Top level of the escape-time fractal unit: sequencer and datapath around one multiplier.
// Depends on etf_pkg, the channels in etf_if.sv, etf_cfg_regs and etf_mul.
// Assertions at the end are left out of synthesis.

// Each accepted pixel beat is mapped to a complex point (origin plus step times index),
// then z = z*z + c is iterated in signed fixed point with FRAC_BITS fraction bits and
// twelve bits for sign and integer part (width capped at 60), in Mandelbrot or Julia mode,
// until |z|^2 passes bailout^2 or the iteration limit is reached. All products go one
// after another through a single shared multiplier. One pixel is in flight at a time;
// the next one is taken while the previous result still waits in the output register.
// Configuration beats are always taken and should be sent only while no pixel is in
// flight.
module escape_time_fractal_unit_core #(
    parameter int COORD_BITS = 10,
    parameter int ITER_BITS  = 12,
    parameter int FRAC_BITS  = 28
) (
    input  logic       clk,
    input  logic       rst_n,
    etf_cfg_if.sink    cfg,
    etf_pix_if.sink    pix,
    etf_res_if.source  res
);

    localparam int ACC_W = (FRAC_BITS + 12 < 60) ? FRAC_BITS + 12 : 60;
    localparam int OPW   = (ACC_W > 32) ? ACC_W : 32;
    localparam int PW    = 2 * OPW;
    localparam int SP_W  = etf_pkg::STEP_W + COORD_BITS;
    localparam int QW    = PW - FRAC_BITS;
    localparam int CW    = (QW > 64) ? QW : 64;
    localparam int MI_W  = (ITER_BITS > etf_pkg::MAX_ITER_MIN_W) ?
                           ITER_BITS : etf_pkg::MAX_ITER_MIN_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_INIT  = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_CHK   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam logic [2:0] OP_PRE_RE = 3'd0;
    localparam logic [2:0] OP_PRE_IM = 3'd1;
    localparam logic [2:0] OP_XX     = 3'd2;
    localparam logic [2:0] OP_YY     = 3'd3;
    localparam logic [2:0] OP_XY     = 3'd4;

    function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [63:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[63:ACC_W-1] == {(65 - ACC_W){v[63]}})
            r = v[ACC_W-1:0];
        else if (v[63])
            r = {1'b1, {(ACC_W - 1){1'b0}}};
        else
            r = {1'b0, {(ACC_W - 1){1'b1}}};
        return r;
    endfunction

    // Floors the magnitude product by FRAC_BITS, rounding toward minus infinity for
    // negative results, and saturates to the product limit.
    function automatic logic signed [63:0] fx_fin(input logic [PW-1:0] p, input logic neg);
        logic [CW-1:0]      q;
        logic               big;
        logic               remnz;
        logic [63:0]        q64;
        logic signed [63:0] r;
        q     = CW'(p[PW-1:FRAC_BITS]);
        big   = q >= CW'(etf_pkg::PROD_LIM);
        remnz = |p[FRAC_BITS-1:0];
        q64   = {2'b00, q[61:0]};
        if (!neg)
            r = big ? $signed(etf_pkg::PROD_LIM) : $signed(q64);
        else if (big)
            r = -$signed(etf_pkg::PROD_LIM);
        else if (remnz)
            r = $signed(~q64);
        else
            r = -$signed(q64);
        return r;
    endfunction

    function automatic logic signed [62:0] clamp_cross(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > etf_pkg::CROSS_LIM)
            r = etf_pkg::CROSS_LIM;
        else if (v < -etf_pkg::CROSS_LIM)
            r = -etf_pkg::CROSS_LIM;
        else
            r = v;
        return r[62:0];
    endfunction

    etf_pkg::cfg_t   cfg_q;
    logic [MI_W-1:0] max_iter;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [2:0]              op_reg;
    logic [2:0]              op_next;
    logic [MI_W-1:0]         iter_reg;
    logic [MI_W-1:0]         iter_next;
    logic                    chk_reg;
    logic                    chk_next;
    logic                    esc_reg;
    logic                    esc_next;
    logic [COORD_BITS-1:0]   px_reg;
    logic [COORD_BITS-1:0]   px_next;
    logic [COORD_BITS-1:0]   py_reg;
    logic [COORD_BITS-1:0]   py_next;
    logic signed [ACC_W-1:0] zr_reg;
    logic signed [ACC_W-1:0] zr_next;
    logic signed [ACC_W-1:0] zi_reg;
    logic signed [ACC_W-1:0] zi_next;
    logic signed [ACC_W-1:0] cr_reg;
    logic signed [ACC_W-1:0] cr_next;
    logic signed [ACC_W-1:0] ci_reg;
    logic signed [ACC_W-1:0] ci_next;
    logic [61:0]             xx_reg;
    logic [61:0]             xx_next;
    logic [61:0]             yy_reg;
    logic [61:0]             yy_next;
    logic signed [62:0]      xy_reg;
    logic signed [62:0]      xy_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [ITER_BITS-1:0]    escape_reg;
    logic [ITER_BITS-1:0]    escape_next;
    logic                    inside_reg;
    logic                    inside_next;

    logic                    mul_start;
    logic                    mul_done;
    logic [OPW-1:0]          mul_a;
    logic [OPW-1:0]          mul_b;
    logic                    mul_neg;
    logic [PW-1:0]           mul_prod;

    logic [ACC_W-1:0]        zr_mag;
    logic [ACC_W-1:0]        zi_mag;
    logic signed [63:0]      fin_val;
    logic signed [63:0]      pre_re_sum;
    logic signed [63:0]      pre_im_sum;
    logic signed [63:0]      sum_r;
    logic signed [63:0]      sum_i;
    logic [62:0]             mag;
    logic [5:0]              bail_sq;
    logic [62:0]             thr;

    etf_cfg_regs #(
        .ITER_BITS (ITER_BITS),
        .MI_W      (MI_W)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_q    (cfg_q),
        .max_iter (max_iter)
    );

    etf_mul #(
        .OPW (OPW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign zr_mag = zr_reg[ACC_W-1] ? (~zr_reg + 1'b1) : zr_reg;
    assign zi_mag = zi_reg[ACC_W-1] ? (~zi_reg + 1'b1) : zi_reg;

    always_comb
    begin
        mul_neg = 1'b0;
        unique case (op_reg)
            OP_PRE_RE:
            begin
                mul_a = OPW'(cfg_q.step_re);
                mul_b = OPW'(px_reg);
            end
            OP_PRE_IM:
            begin
                mul_a = OPW'(cfg_q.step_im);
                mul_b = OPW'(py_reg);
            end
            OP_XX:
            begin
                mul_a = OPW'(zr_mag);
                mul_b = OPW'(zr_mag);
            end
            OP_YY:
            begin
                mul_a = OPW'(zi_mag);
                mul_b = OPW'(zi_mag);
            end
            OP_XY:
            begin
                mul_a   = OPW'(zr_mag);
                mul_b   = OPW'(zi_mag);
                mul_neg = zr_reg[ACC_W-1] ^ zi_reg[ACC_W-1];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign fin_val    = fx_fin(mul_prod, mul_neg);
    assign pre_re_sum = 64'($signed(cfg_q.origin_re)) + $signed(64'(mul_prod[SP_W-1:0]));
    assign pre_im_sum = 64'($signed(cfg_q.origin_im)) + $signed(64'(mul_prod[SP_W-1:0]));
    assign sum_r      = $signed({2'b00, xx_reg}) - $signed({2'b00, yy_reg}) + 64'(cr_reg);
    assign sum_i      = $signed({xy_reg, 1'b0}) + 64'(ci_reg);
    assign mag        = {1'b0, xx_reg} + {1'b0, yy_reg};
    assign bail_sq    = {3'b000, cfg_q.bailout} * {3'b000, cfg_q.bailout};
    assign thr        = 63'(bail_sq) << FRAC_BITS;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        iter_next      = iter_reg;
        chk_next       = chk_reg;
        esc_next       = esc_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        xy_next        = xy_reg;
        escape_next    = escape_reg;
        inside_next    = inside_reg;
        out_valid_next = out_valid_reg && !res.ready;
        mul_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pix.valid)
                begin
                    px_next    = pix.pixel_x;
                    py_next    = pix.pixel_y;
                    op_next    = OP_PRE_RE;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                mul_start  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    unique case (op_reg)
                        OP_PRE_RE:
                        begin
                            cr_next    = clamp_acc(pre_re_sum);
                            op_next    = OP_PRE_IM;
                            state_next = S_ISSUE;
                        end
                        OP_PRE_IM:
                        begin
                            ci_next    = clamp_acc(pre_im_sum);
                            state_next = S_INIT;
                        end
                        OP_XX:
                        begin
                            xx_next    = fin_val[61:0];
                            op_next    = OP_YY;
                            state_next = S_ISSUE;
                        end
                        OP_YY:
                        begin
                            yy_next = fin_val[61:0];
                            if (chk_reg)
                            begin
                                state_next = S_CHK;
                            end
                            else
                            begin
                                op_next    = OP_XY;
                                state_next = S_ISSUE;
                            end
                        end
                        OP_XY:
                        begin
                            xy_next    = clamp_cross(fin_val);
                            state_next = S_UPD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                iter_next = '0;
                chk_next  = 1'b0;
                esc_next  = 1'b0;
                if (cfg_q.mode)
                begin
                    zr_next = cr_reg;
                    zi_next = ci_reg;
                    cr_next = clamp_acc(64'($signed(cfg_q.julia_c[63:32])));
                    ci_next = clamp_acc(64'($signed(cfg_q.julia_c[31:0])));
                end
                else
                begin
                    zr_next = '0;
                    zi_next = '0;
                end
                if (max_iter == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    op_next    = OP_XX;
                    state_next = S_ISSUE;
                end
            end
            S_UPD:
            begin
                zr_next    = clamp_acc(sum_r);
                zi_next    = clamp_acc(sum_i);
                chk_next   = 1'b1;
                op_next    = OP_XX;
                state_next = S_ISSUE;
            end
            S_CHK:
            begin
                if (mag > thr)
                begin
                    esc_next   = 1'b1;
                    state_next = S_FIN;
                end
                else if (MI_W'(iter_reg + 1'b1) == max_iter)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    iter_next  = iter_reg + 1'b1;
                    op_next    = OP_XY;
                    state_next = S_ISSUE;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    escape_next    = esc_reg ? iter_reg[ITER_BITS-1:0] : '0;
                    inside_next    = !esc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_PRE_RE;
            iter_reg      <= '0;
            chk_reg       <= 1'b0;
            esc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            iter_reg      <= iter_next;
            chk_reg       <= chk_next;
            esc_reg       <= esc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        zr_reg     <= zr_next;
        zi_reg     <= zi_next;
        cr_reg     <= cr_next;
        ci_reg     <= ci_next;
        xx_reg     <= xx_next;
        yy_reg     <= yy_next;
        xy_reg     <= xy_next;
        escape_reg <= escape_next;
        inside_reg <= inside_next;
    end

    assign pix.ready       = (state_reg == S_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.escape_iter = escape_reg;
    assign res.inside_res  = inside_reg;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_MUL))
        else $error("multiplier finished outside the wait state");

    a_iter_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> (iter_reg < max_iter))
        else $error("iteration count reached the limit inside the loop");

    a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.inside_res) |-> (res.escape_iter == '0))
        else $error("inside result carries a nonzero escape iteration");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready) |=> (state_reg == S_ISSUE && op_reg == OP_PRE_RE))
        else $error("accepted pixel did not start the coordinate mapping");
`endif

endmodule
